// ===== design/psc_pkg.sv =====
// shared types and constants for the pid steering controller
package psc_pkg;

	localparam int GAIN_W     = 16;
	localparam int LIMIT_W    = 15;
	localparam int WEIGHT_W   = 13;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int GAIN_FRAC  = 8;
	localparam int OUT_FRAC   = 12;
	// multiplier a-operand: gains plus room for the unsigned weight
	localparam int MUL_A_W    = GAIN_W + 1;

	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(4096);

	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_WEIGHT = 3'd4;

	typedef enum logic [1:0] {
		MUL_SEL_P,
		MUL_SEL_I,
		MUL_SEL_D,
		MUL_SEL_BLEND
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     acc_load;
		logic     acc_add;
		logic     clamp;
		logic     finish;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_stat_t;

endpackage

// ===== design/psc_err_if.sv =====
// input channel carrying one error sample per transfer
interface psc_err_if #(
	parameter int DATA_WIDTH = 16
);
	logic                  valid;
	logic                  ready;
	logic [DATA_WIDTH-1:0] error_sample;

	modport source (output valid, output error_sample, input ready);
	modport sink (input valid, input error_sample, output ready);
endinterface

// ===== design/psc_steer_if.sv =====
// result channel carrying the smoothed steer value and clamp flag
interface psc_steer_if #(
	parameter int DATA_WIDTH = 16
);
	logic                  valid;
	logic                  ready;
	logic [DATA_WIDTH-1:0] steer_out;
	logic                  clamped;

	modport source (output valid, output steer_out, output clamped, input ready);
	modport sink (input valid, input steer_out, input clamped, output ready);
endinterface

// ===== design/psc_ctrl.sv =====
// sequencer stepping one sample through the shared multiplier datapath
module psc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  psc_pkg::dp_stat_t  stat,
	output psc_pkg::dp_cmd_t   cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_P,
		ST_MUL_I,
		ST_MUL_D,
		ST_ACC_D,
		ST_CLAMP,
		ST_BLEND,
		ST_DONE
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE:  if (in_valid) state_q <= ST_MUL_P;
				ST_MUL_P: state_q <= ST_MUL_I;
				ST_MUL_I: state_q <= ST_MUL_D;
				ST_MUL_D: state_q <= ST_ACC_D;
				ST_ACC_D: state_q <= ST_CLAMP;
				ST_CLAMP: state_q <= ST_BLEND;
				ST_BLEND: state_q <= ST_DONE;
				ST_DONE:  if (stat.out_free) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd      = '0;
		cmd.mul_sel = psc_pkg::MUL_SEL_P;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_MUL_P: begin
				cmd.mul_en = 1'b1;
			end
			ST_MUL_I: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = psc_pkg::MUL_SEL_I;
				cmd.acc_load = 1'b1;
			end
			ST_MUL_D: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = psc_pkg::MUL_SEL_D;
				cmd.acc_add = 1'b1;
			end
			ST_ACC_D: begin
				cmd.acc_add = 1'b1;
			end
			ST_CLAMP: begin
				cmd.clamp = 1'b1;
			end
			ST_BLEND: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = psc_pkg::MUL_SEL_BLEND;
			end
			ST_DONE: begin
				cmd.finish = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== design/psc_dp.sv =====
// datapath: config registers, loop state, shared multiplier, clamp and blend
module psc_dp #(
	parameter int DATA_WIDTH = 16,
	parameter int SUM_WIDTH  = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [psc_pkg::CFG_IDX_W-1:0]       wr_index,
	input  logic [psc_pkg::CFG_DATA_W-1:0]      wr_data,
	input  logic [DATA_WIDTH-1:0]               sample_data,
	output logic [DATA_WIDTH-1:0]               steer_data,
	output logic                                clamped_data,
	output logic                                res_valid,
	input  logic                                res_ready,
	input  psc_pkg::dp_cmd_t                    cmd,
	output psc_pkg::dp_stat_t                   stat
);

	localparam int DW    = DATA_WIDTH;
	localparam int SW    = SUM_WIDTH;
	localparam int SUMX  = ((SW > DW) ? SW : DW) + 1;
	localparam int BW    = (SW > DW + 1) ? SW : DW + 1;
	localparam int PW    = psc_pkg::MUL_A_W + BW;
	localparam int ACC_W = PW + 2;
	localparam int BL_W  = PW + 1;
	localparam int AW    = psc_pkg::MUL_A_W;

	localparam logic signed [SUMX-1:0] SUM_MAX =
		{{(SUMX - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
	localparam logic signed [SUMX-1:0] SUM_MIN = ~SUM_MAX;
	localparam logic signed [ACC_W-1:0] DATA_MAX =
		{{(ACC_W - DW + 1){1'b0}}, {(DW - 1){1'b1}}};
	localparam logic signed [ACC_W-1:0] RAW_HALF =
		ACC_W'(1 << (psc_pkg::GAIN_FRAC - 1));
	localparam logic signed [BL_W-1:0] BLEND_HALF =
		BL_W'(1 << (psc_pkg::OUT_FRAC - 1));

	// configuration
	logic signed [psc_pkg::GAIN_W-1:0]   kp_q, ki_q, kd_q;
	logic        [psc_pkg::LIMIT_W-1:0]  lim_q;
	logic        [psc_pkg::WEIGHT_W-1:0] wgt_q;

	// loop state
	logic signed [DW-1:0] last_err_q;
	logic signed [SW-1:0] err_sum_q;
	logic signed [DW-1:0] last_steer_q;

	// per-sample working registers
	logic signed [DW-1:0]    e_q;
	logic signed [DW:0]      de_q;
	logic signed [SW-1:0]    s_q;
	logic signed [DW:0]      diff_q;
	logic                    clip_q;
	logic signed [PW-1:0]    prod_q;
	logic signed [ACC_W-1:0] acc_q;

	logic signed [DW-1:0]  steer_q;
	logic                  clamped_q;
	logic                  res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q  <= '0;
			ki_q  <= '0;
			kd_q  <= '0;
			lim_q <= '1;
			wgt_q <= psc_pkg::WEIGHT_ONE;
		end else if (wr_en) begin
			unique case (wr_index)
				psc_pkg::REG_PROP_GAIN:     kp_q  <= $signed(wr_data);
				psc_pkg::REG_INTEG_GAIN:    ki_q  <= $signed(wr_data);
				psc_pkg::REG_DERIV_GAIN:    kd_q  <= $signed(wr_data);
				psc_pkg::REG_OUTPUT_LIMIT:  lim_q <= wr_data[psc_pkg::LIMIT_W-1:0];
				psc_pkg::REG_SMOOTH_WEIGHT: wgt_q <= wr_data[psc_pkg::WEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// sample load: difference and saturating integral
	logic signed [DW-1:0]   e_in;
	logic signed [SUMX-1:0] s_wide;
	logic signed [SW-1:0]   s_sat;

	always_comb begin
		e_in   = $signed(sample_data);
		s_wide = SUMX'(err_sum_q) + SUMX'(e_in);
		if (s_wide > SUM_MAX) begin
			s_sat = SW'(SUM_MAX);
		end else if (s_wide < SUM_MIN) begin
			s_sat = SW'(SUM_MIN);
		end else begin
			s_sat = SW'(s_wide);
		end
	end

	// shared multiplier operands
	logic        [psc_pkg::WEIGHT_W-1:0] wgt_eff;
	logic signed [AW-1:0]                mul_a;
	logic signed [BW-1:0]                mul_b;

	always_comb begin
		wgt_eff = (wgt_q > psc_pkg::WEIGHT_ONE) ? psc_pkg::WEIGHT_ONE : wgt_q;
		unique case (cmd.mul_sel)
			psc_pkg::MUL_SEL_P: begin
				mul_a = AW'(kp_q);
				mul_b = BW'(e_q);
			end
			psc_pkg::MUL_SEL_I: begin
				mul_a = AW'(ki_q);
				mul_b = BW'(s_q);
			end
			psc_pkg::MUL_SEL_D: begin
				mul_a = AW'(kd_q);
				mul_b = BW'(de_q);
			end
			psc_pkg::MUL_SEL_BLEND: begin
				mul_a = $signed({{(AW - psc_pkg::WEIGHT_W){1'b0}}, wgt_eff});
				mul_b = BW'(diff_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// round to q.12, then clamp against the effective limit
	logic signed [ACC_W-1:0] raw;
	logic signed [ACC_W-1:0] lim_x, lim_eff, lim_neg, c_wide;
	logic signed [DW-1:0]    c_val;
	logic                    clip_now;

	always_comb begin
		raw     = (acc_q + RAW_HALF) >>> psc_pkg::GAIN_FRAC;
		lim_x   = $signed({{(ACC_W - psc_pkg::LIMIT_W){1'b0}}, lim_q});
		lim_eff = (lim_x > DATA_MAX) ? DATA_MAX : lim_x;
		lim_neg = -lim_eff;
		priority if (raw > lim_eff) begin
			c_wide   = lim_eff;
			clip_now = 1'b1;
		end else if (raw < lim_neg) begin
			c_wide   = lim_neg;
			clip_now = 1'b1;
		end else begin
			c_wide   = raw;
			clip_now = 1'b0;
		end
		c_val = $signed(c_wide[DW-1:0]);
	end

	// blend: a*(c - last) + last*4096, rounded back to q.12
	logic signed [BL_W-1:0] bsum;
	logic signed [BL_W-1:0] y_wide;
	logic signed [DW-1:0]   y_val;

	always_comb begin
		bsum   = BL_W'(prod_q) + (BL_W'(last_steer_q) <<< psc_pkg::OUT_FRAC) + BLEND_HALF;
		y_wide = bsum >>> psc_pkg::OUT_FRAC;
		y_val  = $signed(y_wide[DW-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_err_q   <= '0;
			err_sum_q    <= '0;
			last_steer_q <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				last_err_q <= e_in;
				err_sum_q  <= s_sat;
			end
			if (cmd.finish) begin
				last_steer_q <= y_val;
				res_valid_q  <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			e_q  <= e_in;
			de_q <= (DW + 1)'(e_in) - (DW + 1)'(last_err_q);
			s_q  <= s_sat;
		end
		if (cmd.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.acc_load) begin
			acc_q <= ACC_W'(prod_q);
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + ACC_W'(prod_q);
		end
		if (cmd.clamp) begin
			diff_q <= (DW + 1)'(c_val) - (DW + 1)'(last_steer_q);
			clip_q <= clip_now;
		end
		if (cmd.finish) begin
			steer_q   <= y_val;
			clamped_q <= clip_q;
		end
	end

	assign stat.out_free = !res_valid_q || res_ready;
	assign res_valid     = res_valid_q;
	assign steer_data    = steer_q;
	assign clamped_data  = clamped_q;

endmodule

// ===== design/pid_steer_clamp_smooth_unit.sv =====
// top level of the pid steering controller with output clamp and smoothing
//
// sample: one signed q4.12 error per transfer (valid/ready). result: one
// smoothed q4.12 steer value and a clamp flag per sample, in order.
// gains, clamp magnitude and smoothing weight are to be written through the
// wr_en / wr_index / wr_data port only while no sample is in flight; the
// block does not enforce it. an index beyond the register list is ignored.
// each sample goes through a load step (difference and saturating
// integral), then a single shared multiplier is used four times in turn
// (p, i, d terms, then the smoothing blend), with one accumulate and one
// clamp step in between, and a done step that registers the result. the
// next sample is taken only once that result is registered.
// the result sits in an output register; if the receiver stalls, the next
// sample is still taken and worked through the blend, then waits until
// the register frees.
// reset clears the loop state (last error, integral, last steer) and puts
// the registers at zero gains, full-scale limit and a weight of one.
module pid_steer_clamp_smooth_unit #(
	parameter int DATA_WIDTH = 16,
	parameter int SUM_WIDTH  = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	psc_err_if.sink                        sample,
	psc_steer_if.source                    result,
	input  logic                           wr_en,
	input  logic [psc_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [psc_pkg::CFG_DATA_W-1:0] wr_data
);

	psc_pkg::dp_cmd_t  cmd;
	psc_pkg::dp_stat_t stat;

	psc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (sample.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	psc_dp #(
		.DATA_WIDTH (DATA_WIDTH),
		.SUM_WIDTH  (SUM_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.sample_data  (sample.error_sample),
		.steer_data   (result.steer_out),
		.clamped_data (result.clamped),
		.res_valid    (result.valid),
		.res_ready    (result.ready),
		.cmd          (cmd),
		.stat         (stat)
	);

endmodule
